// ===== src/tmem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tmem_pkg
// Shared types and constants for the topic-model E-step unit.
// ---------------------------------------------------------------------------
package tmem_pkg;
	typedef enum logic [2:0] {
		KIND_LOAD_THETA = 3'd0,
		KIND_LOAD_PHI   = 3'd1,
		KIND_TOKEN      = 3'd2,
		KIND_CLEAR      = 3'd3,
		KIND_READ       = 3'd4
	} kind_t;

	localparam logic [2:0] SEL_DOC_CNT  = 3'd0;
	localparam logic [2:0] SEL_WORD_CNT = 3'd1;
	localparam logic [2:0] SEL_TOP_CNT  = 3'd2;
	localparam logic [2:0] SEL_DOC_FIS  = 3'd3;
	localparam logic [2:0] SEL_WORD_FIS = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
	localparam logic [47:0] FIS_MAX = 48'hFFFF_FFFF_FFFF;
endpackage
`default_nettype wire

// ===== src/tmem_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tmem_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module tmem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/tmem_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tmem_div
// Restoring divider, one quotient bit per cycle. 48-bit dividend,
// DEN_W-bit divisor, 48-bit quotient; the caller checks the upper bits.
// ---------------------------------------------------------------------------
module tmem_div #(
	parameter int DEN_W = 35
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [47:0]      dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic      [47:0]      quotient
);
	logic [47:0]      quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [DEN_W+1:0] trial;
	logic [DEN_W:0]   shifted;

	assign shifted  = {rem_q, quo_q[47]};
	assign trial    = {1'b0, shifted} - {2'b00, den_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
			end else if (busy_q) begin
				if (!trial[DEN_W+1]) begin
					rem_q <= trial[DEN_W-1:0];
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= shifted[DEN_W-1:0];
					quo_q <= {quo_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/topic_model_em_estep_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// topic_model_em_estep_unit
// E-step engine: responsibilities and observed Fisher terms per token.
// ---------------------------------------------------------------------------
// Input stream s_axis: one transaction per command (load theta/phi, token,
// clear, readout). Output stream m_axis: exactly one transaction per command
// carrying read_data on tdata and status on tuser.
// One command is processed at a time. A load passes through S_LOAD and a
// readout through S_RD0 and S_RD1 before m_axis_tvalid rises; an unused
// kind goes straight to S_OUT. A token reads the TOPICS theta/phi pairs and
// sums the products; then per topic a bit-serial divider runs three times
// (responsibility, two Fisher ratios), the ratios are squared and the five
// tables get a read-modify-write. A zero sum skips the per-topic steps and
// answers with status ST_ZERO. The divider sets the token cost.
// Reset and the clear command run a sweep over the accumulator memories, one
// entry per cycle over max(DOCS,WORDS)*TOPICS entries, during which no
// command is taken. A clear command answers once its sweep has finished.
// While m_axis is stalled the result is held; the next command can be
// accepted in the cycle after the result has been taken.
// ---------------------------------------------------------------------------
module topic_model_em_estep_unit #(
	parameter int TOPICS = 8,
	parameter int DOCS   = 256,
	parameter int WORDS  = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// doc_index[7:0], word_index[17:8], topic_index[20:18],
	// prob_value[36:21], zero fill to 40
	input  wire logic [39:0] s_axis_tdata,
	// kind[2:0], table_select[5:3]
	input  wire logic [5:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_data[47:0]
	output logic      [47:0] m_axis_tdata,
	// status[1:0]
	output logic      [1:0]  m_axis_tuser
);
	localparam int TW  = (TOPICS > 1) ? $clog2(TOPICS) : 1;
	localparam int DW  = (DOCS > 1) ? $clog2(DOCS) : 1;
	localparam int VW  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int DAW = (DOCS * TOPICS > 1) ? $clog2(DOCS * TOPICS) : 1;
	localparam int VAW = (WORDS * TOPICS > 1) ? $clog2(WORDS * TOPICS) : 1;
	localparam int MAXN = (DOCS > WORDS) ? DOCS * TOPICS : WORDS * TOPICS;
	localparam int CW  = $clog2(MAXN + 1);
	// sum of TOPICS products, each below 2^32
	localparam int SW  = 32 + TW;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_LOAD, S_RD0, S_RD1, S_SUM0, S_SUM1, S_K0, S_K1,
		S_DIVG, S_DIVD, S_DIVW, S_SQD, S_SQW, S_WB, S_OUT
	} state_t;

	state_t state_q;

	// index reduction by compare and subtract; inputs are below 2^10
	function automatic logic [31:0] fold_index(logic [31:0] x, logic [31:0] m);
		logic [31:0] r;
		r = x;
		for (int i = 9; i >= 0; i--) begin
			if (r >= (m << i))
				r = r - (m << i);
		end
		return r;
	endfunction

	// field unpacking
	logic [2:0]  in_kind, in_sel, in_top;
	logic [7:0]  in_doc;
	logic [9:0]  in_word;
	logic [15:0] in_prob;
	assign in_kind = s_axis_tuser[2:0];
	assign in_sel  = s_axis_tuser[5:3];
	assign in_doc  = s_axis_tdata[7:0];
	assign in_word = s_axis_tdata[17:8];
	assign in_top  = s_axis_tdata[20:18];
	assign in_prob = s_axis_tdata[36:21];

	logic [2:0]  kind_q, sel_q, top_q;
	logic [DW-1:0] d_q;
	logic [VW-1:0] v_q;
	logic [15:0] prob_q;
	logic [TW:0] k_q;
	logic [CW-1:0] clr_q;
	logic [SW-1:0] sum_q;
	logic [31:0] g_q;
	logic [15:0] th_q, ph_q;
	logic [31:0] rd_q, rw_q;
	logic [47:0] fd_q, fw_q;
	logic        satd_q, satw_q, sat_q;
	logic [47:0] data_q;
	logic [1:0]  stat_q;
	logic [31:0] tc_q [TOPICS];

	logic top_ok;
	assign top_ok = ({29'd0, top_q} < 32'(TOPICS));

	logic [DW-1:0] d_in;
	logic [VW-1:0] v_in;
	assign d_in = DW'(fold_index(32'(in_doc), 32'(DOCS)));
	assign v_in = VW'(fold_index(32'(in_word), 32'(WORDS)));

	// memory addresses
	logic [TW-1:0] tsel;
	assign tsel = (state_q == S_IDLE || state_q == S_LOAD || state_q == S_RD0 ||
		state_q == S_RD1 || state_q == S_OUT) ? top_q[TW-1:0] : k_q[TW-1:0];
	logic [DAW-1:0] da;
	logic [VAW-1:0] va;
	assign da = DAW'(32'(d_q) * 32'(TOPICS) + 32'(tsel));
	assign va = VAW'(32'(v_q) * 32'(TOPICS) + 32'(tsel));

	logic clr_on;
	assign clr_on = (state_q == S_CLR);

	// theta/phi
	logic th_we, ph_we;
	logic [15:0] th_rd, ph_rd;
	logic [31:0] prod;
	assign th_we = (state_q == S_LOAD) && kind_q == tmem_pkg::KIND_LOAD_THETA && top_ok;
	assign ph_we = (state_q == S_LOAD) && kind_q == tmem_pkg::KIND_LOAD_PHI && top_ok;
	tmem_ram #(.WIDTH(16), .DEPTH(DOCS * TOPICS)) u_theta (.clk(clk), .we(th_we),
		.waddr(da), .wdata(prob_q), .raddr(da), .rdata(th_rd));
	tmem_ram #(.WIDTH(16), .DEPTH(WORDS * TOPICS)) u_phi (.clk(clk), .we(ph_we),
		.waddr(va), .wdata(prob_q), .raddr(va), .rdata(ph_rd));
	assign prod = 32'(th_rd) * 32'(ph_rd);

	// accumulators
	logic wb;
	assign wb = (state_q == S_WB);
	logic [DAW-1:0] dwa;
	logic [VAW-1:0] vwa;
	assign dwa = clr_on ? DAW'(clr_q) : da;
	assign vwa = clr_on ? VAW'(clr_q) : va;
	logic dcw, vcw;
	assign dcw = wb || (clr_on && 32'(clr_q) < DOCS * TOPICS);
	assign vcw = wb || (clr_on && 32'(clr_q) < WORDS * TOPICS);
	logic [31:0] dc_rd, vc_rd;
	logic [47:0] df_rd, vf_rd;
	tmem_ram #(.WIDTH(32), .DEPTH(DOCS * TOPICS)) u_dcnt (.clk(clk), .we(dcw),
		.waddr(dwa), .wdata(clr_on ? 32'd0 : rd_q), .raddr(da), .rdata(dc_rd));
	tmem_ram #(.WIDTH(32), .DEPTH(WORDS * TOPICS)) u_vcnt (.clk(clk), .we(vcw),
		.waddr(vwa), .wdata(clr_on ? 32'd0 : rw_q), .raddr(va), .rdata(vc_rd));
	tmem_ram #(.WIDTH(48), .DEPTH(DOCS * TOPICS)) u_dfis (.clk(clk), .we(dcw),
		.waddr(dwa), .wdata(clr_on ? 48'd0 : fd_q), .raddr(da), .rdata(df_rd));
	tmem_ram #(.WIDTH(48), .DEPTH(WORDS * TOPICS)) u_vfis (.clk(clk), .we(vcw),
		.waddr(vwa), .wdata(clr_on ? 48'd0 : fw_q), .raddr(va), .rdata(vf_rd));

	// divider
	logic        dv_start, dv_done;
	logic [47:0] dv_num, dv_q;
	tmem_div #(.DEN_W(SW)) u_div (.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(dv_num), .divisor(sum_q), .done(dv_done), .quotient(dv_q));

	// saturating adds
	logic [32:0] sdc, svc, stc;
	logic [48:0] sdf, svf;
	logic [63:0] sq;
	logic [47:0] fterm_d, fterm_w;
	assign sq = 64'(rw_q) * 64'(rw_q); // rw_q holds the ratio during squaring
	assign fterm_d = satd_q ? tmem_pkg::FIS_MAX : fd_q;
	assign fterm_w = satw_q ? tmem_pkg::FIS_MAX : fw_q;
	assign sdc = {1'b0, dc_rd} + {1'b0, g_q};
	assign svc = {1'b0, vc_rd} + {1'b0, g_q};
	assign stc = {1'b0, tc_q[k_q[TW-1:0]]} + {1'b0, g_q};
	assign sdf = {1'b0, df_rd} + {1'b0, fterm_d};
	assign svf = {1'b0, vf_rd} + {1'b0, fterm_w};

	always_comb begin
		dv_start = 1'b0;
		dv_num   = '0;
		case (state_q)
			S_K1: begin
				dv_start = 1'b1;
				dv_num   = {prod, 16'd0};
			end
			S_DIVG: begin
				dv_start = dv_done;
				dv_num   = {ph_q, 32'd0};
			end
			S_DIVD: begin
				dv_start = dv_done;
				dv_num   = {th_q, 32'd0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			kind_q        <= tmem_pkg::KIND_LOAD_THETA;
			data_q        <= '0;
			stat_q        <= tmem_pkg::ST_OK;
			s_axis_tready <= 1'b0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < TOPICS; i++) tc_q[i] <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAXN - 1) begin
						if (kind_q == tmem_pkg::KIND_CLEAR) begin
							data_q        <= '0;
							stat_q        <= tmem_pkg::ST_OK;
							state_q       <= S_OUT;
							m_axis_tvalid <= 1'b1;
						end else begin
							state_q       <= S_IDLE;
							s_axis_tready <= 1'b1;
						end
						kind_q <= tmem_pkg::KIND_LOAD_THETA;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						s_axis_tready <= 1'b0;
						kind_q <= in_kind;
						d_q    <= d_in;
						v_q    <= v_in;
						top_q  <= in_top;
						prob_q <= in_prob;
						sel_q  <= in_sel;
						k_q    <= '0;
						sum_q  <= '0;
						sat_q  <= 1'b0;
						data_q <= '0;
						stat_q <= tmem_pkg::ST_OK;
						case (in_kind)
							tmem_pkg::KIND_LOAD_THETA,
							tmem_pkg::KIND_LOAD_PHI: state_q <= S_LOAD;
							tmem_pkg::KIND_TOKEN: state_q <= S_SUM0;
							tmem_pkg::KIND_CLEAR: begin
								for (int i = 0; i < TOPICS; i++) tc_q[i] <= '0;
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							tmem_pkg::KIND_READ: state_q <= S_RD0;
							default: begin
								state_q       <= S_OUT;
								m_axis_tvalid <= 1'b1;
							end
						endcase
					end
				end
				S_LOAD: begin
					state_q       <= S_OUT;
					m_axis_tvalid <= 1'b1;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					if (top_ok) begin
						case (sel_q)
							tmem_pkg::SEL_DOC_CNT:  data_q <= {16'd0, dc_rd};
							tmem_pkg::SEL_WORD_CNT: data_q <= {16'd0, vc_rd};
							tmem_pkg::SEL_TOP_CNT:  data_q <= {16'd0, tc_q[top_q[TW-1:0]]};
							tmem_pkg::SEL_DOC_FIS:  data_q <= df_rd;
							tmem_pkg::SEL_WORD_FIS: data_q <= vf_rd;
							default:                data_q <= '0;
						endcase
					end
					state_q       <= S_OUT;
					m_axis_tvalid <= 1'b1;
				end
				S_SUM0: state_q <= S_SUM1;
				S_SUM1: begin
					sum_q <= sum_q + SW'(prod);
					if (32'(k_q) == TOPICS - 1) begin
						k_q     <= '0;
						state_q <= S_K0;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SUM0;
					end
				end
				S_K0: begin
					if (sum_q == '0) begin
						stat_q        <= tmem_pkg::ST_ZERO;
						state_q       <= S_OUT;
						m_axis_tvalid <= 1'b1;
					end else
						state_q <= S_K1;
				end
				S_K1: begin
					th_q    <= th_rd;
					ph_q    <= ph_rd;
					state_q <= S_DIVG;
				end
				S_DIVG: if (dv_done) begin
					g_q     <= dv_q[31:0];
					state_q <= S_DIVD;
				end
				S_DIVD: if (dv_done) begin
					rw_q    <= dv_q[31:0];
					satd_q  <= |dv_q[47:32];
					state_q <= S_DIVW;
				end
				S_DIVW: if (dv_done) begin
					fd_q    <= sq[63:16];
					rw_q    <= dv_q[31:0];
					satw_q  <= |dv_q[47:32];
					state_q <= S_SQW;
				end
				S_SQW: begin
					fw_q    <= sq[63:16];
					state_q <= S_SQD;
				end
				S_SQD: begin
					// compute sums and register write data
					rd_q <= sdc[32] ? tmem_pkg::CNT_MAX : sdc[31:0];
					rw_q <= svc[32] ? tmem_pkg::CNT_MAX : svc[31:0];
					tc_q[k_q[TW-1:0]] <= stc[32] ? tmem_pkg::CNT_MAX : stc[31:0];
					fd_q <= sdf[48] ? tmem_pkg::FIS_MAX : sdf[47:0];
					fw_q <= svf[48] ? tmem_pkg::FIS_MAX : svf[47:0];
					if (sdc[32] || svc[32] || stc[32] || sdf[48] || svf[48] ||
						satd_q || satw_q)
						sat_q <= 1'b1;
					state_q <= S_WB;
				end
				S_WB: begin
					if (32'(k_q) == TOPICS - 1) begin
						stat_q        <= sat_q ? tmem_pkg::ST_SAT : tmem_pkg::ST_OK;
						state_q       <= S_OUT;
						m_axis_tvalid <= 1'b1;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_K0;
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						s_axis_tready <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = data_q;
	assign m_axis_tuser = stat_q;
endmodule
`default_nettype wire

// ===== bench/topic_model_em_estep_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// topic_model_em_estep_unit_tb
// Self-checking bench for the topic-model E-step unit: loads, tokens, clears
// and readouts go in on s_axis; every m_axis transaction is checked against
// a behavioral predictor of the accumulator tables.
// ---------------------------------------------------------------------------
module topic_model_em_estep_unit_tb;
	localparam int NTOP  = 8;
	localparam int NDOC  = 256;
	localparam int NWORD = 1024;
	localparam longint CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  doc;
		logic [9:0]  word;
		logic [2:0]  topic;
		logic [15:0] prob;
		logic [2:0]  sel;
	} cmd_t;

	typedef struct packed {
		logic [47:0] data;
		logic [1:0]  status;
	} resp_t;

	class estep_scoreboard;
		bit [15:0] theta[NDOC*NTOP];
		bit [15:0] phi[NWORD*NTOP];
		bit [31:0] doc_cnt[NDOC*NTOP];
		bit [31:0] word_cnt[NWORD*NTOP];
		bit [31:0] top_cnt[NTOP];
		bit [47:0] doc_fis[NDOC*NTOP];
		bit [47:0] word_fis[NWORD*NTOP];
		resp_t pending[$];
		int mismatches;
		int checked;
		int n_zero, n_sat, n_tokens;

		function void clear_tables();
			foreach (doc_cnt[i]) doc_cnt[i] = '0;
			foreach (word_cnt[i]) word_cnt[i] = '0;
			foreach (top_cnt[i]) top_cnt[i] = '0;
			foreach (doc_fis[i]) doc_fis[i] = '0;
			foreach (word_fis[i]) word_fis[i] = '0;
		endfunction

		function bit [31:0] cnt_add(bit [31:0] a, bit [31:0] b, ref bit sat);
			bit [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (s[32]) begin
				sat = 1;
				return tmem_pkg::CNT_MAX;
			end
			return s[31:0];
		endfunction

		function bit [47:0] fis_add(bit [47:0] a, bit [47:0] b, ref bit sat);
			bit [48:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (s[48]) begin
				sat = 1;
				return tmem_pkg::FIS_MAX;
			end
			return s[47:0];
		endfunction

		// (x / sum)^2 in Q0.48; a ratio of 1.0 or more saturates
		function bit [47:0] fisher(bit [15:0] x, bit [63:0] sum, ref bit sat);
			bit [63:0] r;
			bit [63:0] sq;
			r = 64'({x, 32'h0}) / sum;
			if (r >= 64'h1_0000_0000) begin
				sat = 1;
				return tmem_pkg::FIS_MAX;
			end
			sq = r * r;
			return sq[63:16];
		endfunction

		function void note_command(cmd_t c);
			resp_t e;
			bit [63:0] prod[NTOP];
			bit [63:0] sum;
			bit [31:0] g;
			bit sat;
			int di, vi;
			e = '0;
			sum = 0;
			sat = 0;
			if (c.kind == tmem_pkg::KIND_LOAD_THETA) theta[c.doc*NTOP + c.topic] = c.prob;
			else if (c.kind == tmem_pkg::KIND_LOAD_PHI) phi[c.word*NTOP + c.topic] = c.prob;
			else if (c.kind == tmem_pkg::KIND_TOKEN) begin
				n_tokens++;
				for (int k = 0; k < NTOP; k++) begin
					prod[k] = 64'(theta[c.doc*NTOP + k]) * 64'(phi[c.word*NTOP + k]);
					sum += prod[k];
				end
				if (sum == 0) begin
					e.status = tmem_pkg::ST_ZERO;
					n_zero++;
				end else begin
					for (int k = 0; k < NTOP; k++) begin
						di = c.doc*NTOP + k;
						vi = c.word*NTOP + k;
						g = 32'((prod[k] << 16) / sum);
						doc_cnt[di] = cnt_add(doc_cnt[di], g, sat);
						word_cnt[vi] = cnt_add(word_cnt[vi], g, sat);
						top_cnt[k] = cnt_add(top_cnt[k], g, sat);
						doc_fis[di] = fis_add(doc_fis[di], fisher(phi[vi], sum, sat), sat);
						word_fis[vi] = fis_add(word_fis[vi], fisher(theta[di], sum, sat), sat);
					end
					if (sat) begin
						e.status = tmem_pkg::ST_SAT;
						n_sat++;
					end
				end
			end else if (c.kind == tmem_pkg::KIND_CLEAR) clear_tables();
			else if (c.kind == tmem_pkg::KIND_READ) begin
				case (c.sel)
					tmem_pkg::SEL_DOC_CNT:  e.data = 48'(doc_cnt[c.doc*NTOP + c.topic]);
					tmem_pkg::SEL_WORD_CNT: e.data = 48'(word_cnt[c.word*NTOP + c.topic]);
					tmem_pkg::SEL_TOP_CNT:  e.data = 48'(top_cnt[c.topic]);
					tmem_pkg::SEL_DOC_FIS:  e.data = doc_fis[c.doc*NTOP + c.topic];
					tmem_pkg::SEL_WORD_FIS: e.data = word_fis[c.word*NTOP + c.topic];
					default:                e.data = '0;
				endcase
			end
			pending.push_back(e);
		endfunction

		function void check_result(resp_t got);
			resp_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result data=%h status=%0d",
						$realtime, got.data, got.status);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.data !== e.data || got.status !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp data=%h status=%0d got data=%h status=%0d",
						$realtime, e.data, e.status, got.data, got.status);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire logic   s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [5:0]  s_axis_tuser;
	wire logic   m_axis_tvalid;
	logic        m_axis_tready;
	wire logic [47:0] m_axis_tdata;
	wire logic [1:0]  m_axis_tuser;

	topic_model_em_estep_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	estep_scoreboard sb = new();

	int     idle_phase;      // 0: sender light/receiver heavy, 1: swapped, 2: none
	int     sent;
	bit     hold_done;
	longint cycles;

	// rows whose eight topics are all loaded; only these may feed a token
	bit [NTOP-1:0] theta_loaded[NDOC];
	bit [NTOP-1:0] phi_loaded[NWORD];
	int ready_docs[$];
	int ready_words[$];

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("topic_model_em_estep_unit verification failed");
				$finish;
			end
		end
	end

	// receiver: random stall per phase, plus one long hold-off
	initial begin
		int hold;
		hold = 0;
		hold_done = 0;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent >= 700) begin
				hold = 3000;
				hold_done = 1;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (idle_phase == 0)
				m_axis_tready <= ($urandom_range(0, 99) >= 54);
			else if (idle_phase == 1)
				m_axis_tready <= ($urandom_range(0, 99) >= 12);
			else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(resp_t'({m_axis_tdata, m_axis_tuser}));
	end

	function automatic logic [39:0] pack_data(cmd_t c);
		return {3'b0, c.prob, c.topic, c.word, c.doc};
	endfunction

	function automatic logic [5:0] pack_user(cmd_t c);
		return {c.sel, c.kind};
	endfunction

	function automatic void track_load(cmd_t c);
		if (c.kind == tmem_pkg::KIND_LOAD_THETA && theta_loaded[c.doc] != '1) begin
			theta_loaded[c.doc][c.topic] = 1;
			if (theta_loaded[c.doc] == '1) ready_docs.push_back(int'(c.doc));
		end
		if (c.kind == tmem_pkg::KIND_LOAD_PHI && phi_loaded[c.word] != '1) begin
			phi_loaded[c.word][c.topic] = 1;
			if (phi_loaded[c.word] == '1) ready_words.push_back(int'(c.word));
		end
	endfunction

	task automatic send(cmd_t c);
		int gap;
		gap = 0;
		if (idle_phase == 0 && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 4);
		if (idle_phase == 1 && $urandom_range(0, 99) < 54) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_data(c);
		s_axis_tuser  <= pack_user(c);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(c);
		track_load(c);
		sent++;
	endtask

	function automatic cmd_t mk(logic [2:0] kind, int doc, int word, int topic,
			int prob, int sel);
		cmd_t c;
		c.kind = kind;
		c.doc = 8'(doc);
		c.word = 10'(word);
		c.topic = 3'(topic);
		c.prob = 16'(prob);
		c.sel = 3'(sel);
		return c;
	endfunction

	function automatic logic [15:0] rand_prob();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 16));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int r;
		c.kind = tmem_pkg::KIND_LOAD_THETA;
		c.doc = 8'($urandom);
		c.word = 10'($urandom);
		c.topic = 3'($urandom);
		c.sel = 3'($urandom);
		c.prob = rand_prob();
		r = $urandom_range(0, 999);
		if (r < 3) c.kind = tmem_pkg::KIND_CLEAR;
		else if (r < 20) c.kind = 3'($urandom_range(5, 7));
		else if (r < 260 && ready_docs.size() > 0 && ready_words.size() > 0) begin
			c.kind = tmem_pkg::KIND_TOKEN;
			c.doc = 8'(ready_docs[$urandom_range(0, ready_docs.size() - 1)]);
			c.word = 10'(ready_words[$urandom_range(0, ready_words.size() - 1)]);
		end else if (r < 520) begin
			c.kind = tmem_pkg::KIND_READ;
			c.sel = (r < 510) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
			if (ready_docs.size() > 0 && $urandom_range(0, 9) < 7)
				c.doc = 8'(ready_docs[$urandom_range(0, ready_docs.size() - 1)]);
			if (ready_words.size() > 0 && $urandom_range(0, 9) < 7)
				c.word = 10'(ready_words[$urandom_range(0, ready_words.size() - 1)]);
		end else if (r < 760) begin
			c.kind = tmem_pkg::KIND_LOAD_THETA;
			// keep filling a few rows so tokens have material
			if ($urandom_range(0, 1)) c.doc = 8'($urandom_range(0, 15) * 17);
		end else begin
			c.kind = tmem_pkg::KIND_LOAD_PHI;
			if ($urandom_range(0, 1)) c.word = 10'($urandom_range(0, 15) * 68);
		end
		return c;
	endfunction

	initial begin
		int wait_cycles;
		idle_phase = 0;
		sent = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		foreach (theta_loaded[i]) theta_loaded[i] = '0;
		foreach (phi_loaded[i]) phi_loaded[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a single tiny product saturates the Fisher ratio
		for (int k = 0; k < NTOP; k++)
			send(mk(tmem_pkg::KIND_LOAD_THETA, 0, 0, k, (k == 0) ? 1 : 0, 0));
		for (int k = 0; k < NTOP; k++)
			send(mk(tmem_pkg::KIND_LOAD_PHI, 0, 0, k, (k == 0) ? 1 : 0, 0));
		send(mk(tmem_pkg::KIND_TOKEN, 0, 0, 0, 0, 0));
		send(mk(tmem_pkg::KIND_LOAD_THETA, 0, 0, 0, 0, 0));
		send(mk(tmem_pkg::KIND_TOKEN, 0, 0, 0, 0, 0));          // zero sum, skipped
		send(mk(tmem_pkg::KIND_LOAD_THETA, 0, 0, 0, 'hFFFF, 0));
		send(mk(tmem_pkg::KIND_LOAD_PHI, 0, 0, 0, 'hFFFF, 0));
		send(mk(tmem_pkg::KIND_TOKEN, 0, 0, 0, 0, 0));
		for (int s = 0; s <= 5; s++) send(mk(tmem_pkg::KIND_READ, 0, 0, 0, 0, s));
		send(mk(3'd7, 255, 1023, 7, 'hFFFF, 7));  // unused kind
		send(mk(tmem_pkg::KIND_CLEAR, 0, 0, 0, 0, 0));
		send(mk(tmem_pkg::KIND_READ, 0, 0, 0, 0, int'(tmem_pkg::SEL_TOP_CNT)));

		for (int i = 0; i < 1400; i++) begin
			idle_phase = (i < 470) ? 0 : (i < 940) ? 1 : 2;
			send(rand_cmd());
		end
		s_axis_tvalid <= 1'b0;

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2000) @(posedge clk);

		$display("%0d commands sent, %0d results checked; %0d tokens (%0d zero-sum, %0d saturated)",
			sent, sb.checked, sb.n_tokens, sb.n_zero, sb.n_sat);
		$display("%0d results never arrived, %0d mismatches", sb.pending.size(), sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("topic_model_em_estep_unit verification clean");
		else
			$display("topic_model_em_estep_unit verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/tmem_pkg.sv
src/tmem_ram.sv
src/tmem_div.sv
src/topic_model_em_estep_unit.sv
bench/topic_model_em_estep_unit_tb.sv
